// ===== src/bvce_pkg.sv =====
// Package for the battery voltage charge estimator.
// Holds the sequencer state type, register indexes, charge states and fixed thresholds.
// No dependencies.
package bvce_pkg;

    // Width of the shared serial divider.
    localparam int DIV_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COND,
        ST_READ,
        ST_SPAN,
        ST_MUL,
        ST_TWAIT,
        ST_PCT,
        ST_PWAIT,
        ST_FIN
    } seq_state_t;

    typedef enum logic [1:0] {
        REG_EMPTY_MV,
        REG_FULL_MV,
        REG_SAMPLE_GAP,
        REG_SLEW_STEP
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CS_BATTERY,
        CS_USB,
        CS_CHARGING,
        CS_FULL
    } charge_state_t;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Voltage thresholds in millivolts.
    localparam logic [12:0] RAIL_HIGH_MV     = 13'd4200;
    localparam logic [12:0] RAIL_ARM_LAST_MV = 13'd3980;
    localparam logic [12:0] RAIL_ARM_RAW_MV  = 13'd4050;
    localparam logic [12:0] PACK_LOW_MV      = 13'd2800;
    localparam logic [12:0] RAIL_RELEASE_MV  = 13'd4000;
    localparam logic [12:0] DEFAULT_MV       = 13'd3700;
    localparam logic [12:0] FULL_MIN_MV      = 13'd4120;
    localparam logic signed [13:0] JUMP_MV   = 14'sd200;
    localparam logic signed [14:0] PCT_MARGIN_MV = 15'sd50;

    // Trend thresholds in mV per minute.
    localparam logic signed [17:0] RISE_TREND = 18'sd25;
    localparam logic signed [17:0] HOLD_TREND = -18'sd25;
    localparam logic signed [17:0] KEEP_TREND = -18'sd40;
    localparam logic signed [17:0] TREND_MAX  = 18'sd131071;
    localparam logic signed [17:0] TREND_MIN  = -18'sd131072;

    localparam logic [31:0] MIN_SPAN_MS = 32'd1000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;

    localparam logic [6:0] PCT_MIN   = 7'd1;
    localparam logic [6:0] PCT_CAP   = 7'd99;
    localparam logic [6:0] PCT_MAX   = 7'd100;
    localparam logic [6:0] PCT_RESET = 7'd50;

    localparam logic [3:0] STREAK_MAX  = 4'd10;
    localparam logic [3:0] STREAK_FULL = 4'd3;

endpackage

// ===== src/bvce_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on bvce_pkg for the request and response structs.
module bvce_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bvce_pkg::div_req_t req,
    output bvce_pkg::div_rsp_t rsp
);

    localparam int W     = bvce_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0]   trial;
    logic         fits;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/battery_voltage_charge_estimator.sv =====
// Top level of the battery voltage charge estimator.
// Depends on bvce_pkg and on bvce_div, the shared serial divider.
//
// Each input transfer carries one battery reading, a millisecond timestamp and a USB-present
// flag, and yields exactly one result transfer with the conditioned voltage, the trend in mV
// per minute, the charge percent, the charge state and the rail latch. The block works on one
// item at a time: a new input is taken only in the idle state, after the previous result is
// loaded. The item passes through conditioning and ring access (states COND, READ and SPAN),
// then one 32-bit restoring division for the trend (started in MUL) and a second for the
// percent, both on the single shared divider at one quotient bit per cycle, and a final step
// (FIN) that loads the result. Divisions that are not needed (no trend to form, percent
// clamped) are skipped, so an item may finish sooner.
// The result sits in an output register, so a new item is accepted while the previous result
// still waits; the sequencer only holds its last step if that register is still occupied.
// The history ring is a small memory with one write port and one registered read port; its
// contents are not cleared at reset, a fill count marks which entries hold samples. The newest
// sample is also kept in registers so that only the oldest entry needs a memory read.
// Configuration registers sit on an APB-style port at byte addresses 0, 4, 8 and 12
// (empty_mv, full_mv, sample_gap_ms, slew_step_mv) and must be written only while idle.
module battery_voltage_charge_estimator #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [12:0] s_raw_mv,
    input  logic [31:0] s_time_ms,
    input  logic        s_usb_present,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [12:0]        m_battery_mv,
    output logic signed [17:0] m_trend_mv_per_min,
    output logic [6:0]         m_percent,
    output logic [1:0]         m_charge_state,
    output logic               m_rail_latched,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DW    = bvce_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] empty_mv_reg;
    logic [12:0] full_mv_reg;
    logic [15:0] sample_gap_reg;
    logic [7:0]  slew_step_reg;

    bvce_pkg::cfg_reg_t cfg_index;
    logic               cfg_write;

    assign cfg_index = bvce_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_mv_reg   <= 13'd3300;
            full_mv_reg    <= 13'd4150;
            sample_gap_reg <= 16'd800;
            slew_step_reg  <= 8'd40;
        end else if (cfg_write) begin
            unique case (cfg_index)
                bvce_pkg::REG_EMPTY_MV:   empty_mv_reg   <= pwdata[12:0];
                bvce_pkg::REG_FULL_MV:    full_mv_reg    <= pwdata[12:0];
                bvce_pkg::REG_SAMPLE_GAP: sample_gap_reg <= pwdata[15:0];
                bvce_pkg::REG_SLEW_STEP:  slew_step_reg  <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            bvce_pkg::REG_EMPTY_MV:   prdata = {19'd0, empty_mv_reg};
            bvce_pkg::REG_FULL_MV:    prdata = {19'd0, full_mv_reg};
            bvce_pkg::REG_SAMPLE_GAP: prdata = {16'd0, sample_gap_reg};
            bvce_pkg::REG_SLEW_STEP:  prdata = {24'd0, slew_step_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and persistent state
    // ------------------------------------------------------------------
    bvce_pkg::seq_state_t state_reg, state_next;

    // The accepted item.
    logic [12:0] raw_reg;
    logic [31:0] time_reg;
    logic        usb_reg;

    // State carried from item to item.
    logic             rail_reg;
    logic [12:0]      last_good_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] head_reg;
    logic [12:0]      newest_mv_reg;
    logic [31:0]      newest_ms_reg;
    logic [3:0]       streak_reg;
    bvce_pkg::charge_state_t prev_state_reg;
    logic [6:0]       shown_reg;

    // Working values of the current item.
    logic [12:0]        mv_reg;
    logic [12:0]        dv_abs_reg;
    logic               dv_neg_reg;
    logic [31:0]        span_reg;
    logic signed [17:0] trend_reg;
    logic [6:0]         pct_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [12:0]             out_mv_reg;
    logic signed [17:0]      out_trend_reg;
    logic [6:0]              out_pct_reg;
    bvce_pkg::charge_state_t out_state_reg;
    logic                    out_rail_reg;

    bvce_pkg::div_req_t div_req;
    bvce_pkg::div_rsp_t div_rsp;

    bvce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Reading conditioning: rail latch, range check and slew limit
    // ------------------------------------------------------------------
    logic               rail_next;
    logic               have_good;
    logic signed [13:0] raw_minus_lg;
    logic [12:0]        cond_mv;
    logic               lg_update;
    logic [31:0]        gap_ms;
    logic               store_en;
    logic [PTR_W-1:0]   head_next;

    always_comb begin
        have_good    = last_good_reg != 13'd0;
        raw_minus_lg = $signed({1'b0, raw_reg}) - $signed({1'b0, last_good_reg});

        if (raw_reg > bvce_pkg::RAIL_HIGH_MV) begin
            rail_next = 1'b1;
        end else if (have_good && last_good_reg < bvce_pkg::RAIL_ARM_LAST_MV
                     && raw_reg >= bvce_pkg::RAIL_ARM_RAW_MV) begin
            rail_next = 1'b1;
        end else if (rail_reg && raw_reg >= bvce_pkg::PACK_LOW_MV
                     && raw_reg < bvce_pkg::RAIL_RELEASE_MV) begin
            rail_next = 1'b0;
        end else begin
            rail_next = rail_reg;
        end

        lg_update = 1'b1;
        if (rail_next || raw_reg > bvce_pkg::RAIL_HIGH_MV || raw_reg < bvce_pkg::PACK_LOW_MV) begin
            // Rejected reading: hold the last good value, or a default before any.
            cond_mv   = have_good ? last_good_reg : bvce_pkg::DEFAULT_MV;
            lg_update = 1'b0;
        end else if (have_good && (raw_minus_lg > bvce_pkg::JUMP_MV
                                   || raw_minus_lg < -bvce_pkg::JUMP_MV)) begin
            // Large jump: move one slew step, which may overshoot the reading.
            cond_mv = (raw_minus_lg > 14'sd0) ? 13'(last_good_reg + {5'd0, slew_step_reg})
                                              : 13'(last_good_reg - {5'd0, slew_step_reg});
        end else begin
            cond_mv = raw_reg;
        end

        gap_ms    = time_reg - newest_ms_reg;
        store_en  = (state_reg == bvce_pkg::ST_COND)
                    && (count_reg == '0 || gap_ms >= {16'd0, sample_gap_reg});
        head_next = (head_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    // ------------------------------------------------------------------
    // History ring: one write port, one registered read of the oldest entry
    // ------------------------------------------------------------------
    logic [12:0]      hist_mv_mem [HISTORY_DEPTH];
    logic [31:0]      hist_ms_mem [HISTORY_DEPTH];
    logic [PTR_W-1:0] oldest_idx;
    logic [12:0]      old_mv_reg;
    logic [31:0]      old_ms_reg;

    assign oldest_idx = (count_reg == CNT_W'(HISTORY_DEPTH)) ? head_reg : '0;

    always_ff @(posedge aclk) begin
        if (store_en) begin
            hist_mv_mem[head_reg] <= cond_mv;
            hist_ms_mem[head_reg] <= time_reg;
        end
    end

    always_ff @(posedge aclk) begin
        old_mv_reg <= hist_mv_mem[oldest_idx];
        old_ms_reg <= hist_ms_mem[oldest_idx];
    end

    // ------------------------------------------------------------------
    // Trend set-up and saturation
    // ------------------------------------------------------------------
    logic [31:0]        span_u;
    logic               trend_ok;
    logic signed [13:0] dv;
    logic signed [17:0] trend_sat;

    always_comb begin
        span_u   = newest_ms_reg - old_ms_reg;
        // A span of under one second, or one that reads as negative, gives no trend.
        trend_ok = (count_reg >= CNT_W'(2)) && !span_u[31] && (span_u >= bvce_pkg::MIN_SPAN_MS);
        dv       = $signed({1'b0, newest_mv_reg}) - $signed({1'b0, old_mv_reg});

        // The quotient is a magnitude; apply the sign and saturate to 18 bits.
        if (dv_neg_reg) begin
            trend_sat = (div_rsp.quotient > 32'd131072) ? bvce_pkg::TREND_MIN
                                                        : -$signed(div_rsp.quotient[17:0]);
        end else begin
            trend_sat = (div_rsp.quotient > 32'd131071) ? bvce_pkg::TREND_MAX
                                                        : $signed(div_rsp.quotient[17:0]);
        end
    end

    // ------------------------------------------------------------------
    // Percent set-up
    // ------------------------------------------------------------------
    logic signed [14:0] pct_d;
    logic signed [14:0] pct_n;
    logic signed [21:0] pct_n100;

    always_comb begin
        pct_d    = $signed({2'b0, full_mv_reg}) - $signed({2'b0, empty_mv_reg})
                   - bvce_pkg::PCT_MARGIN_MV;
        pct_n    = $signed({2'b0, mv_reg}) - $signed({2'b0, empty_mv_reg});
        pct_n100 = 22'(pct_n) * 22'sd100;
    end

    // ------------------------------------------------------------------
    // Charge state decision
    // ------------------------------------------------------------------
    logic                    streak_cond;
    logic [3:0]              streak_next;
    logic                    is_full;
    logic                    rising;
    logic                    holding;
    bvce_pkg::charge_state_t cs_next;
    logic [6:0]              pct_out;
    logic [6:0]              shown_next;
    logic                    fin_go;

    always_comb begin
        streak_cond = pct_reg >= bvce_pkg::PCT_CAP
                      && mv_reg >= bvce_pkg::FULL_MIN_MV && mv_reg <= bvce_pkg::RAIL_HIGH_MV
                      && (prev_state_reg == bvce_pkg::CS_CHARGING
                          || prev_state_reg == bvce_pkg::CS_FULL);
        if (!streak_cond) begin
            streak_next = '0;
        end else if (streak_reg < bvce_pkg::STREAK_MAX) begin
            streak_next = streak_reg + 1'b1;
        end else begin
            streak_next = streak_reg;
        end
        is_full = streak_next >= bvce_pkg::STREAK_FULL && !rail_reg;
        rising  = trend_reg >= bvce_pkg::RISE_TREND;
        holding = mv_reg >= bvce_pkg::RAIL_RELEASE_MV && mv_reg <= bvce_pkg::RAIL_HIGH_MV
                  && trend_reg > bvce_pkg::HOLD_TREND;

        shown_next = shown_reg;
        if (rail_reg) begin
            // While latched on the rail the percent is frozen and no full streak builds up.
            pct_out     = (shown_reg > bvce_pkg::PCT_CAP) ? bvce_pkg::PCT_CAP : shown_reg;
            cs_next     = usb_reg ? bvce_pkg::CS_USB : bvce_pkg::CS_BATTERY;
            streak_next = '0;
        end else begin
            priority if (is_full) begin
                cs_next = bvce_pkg::CS_FULL;
            end else if (usb_reg) begin
                cs_next = rising ? bvce_pkg::CS_CHARGING : bvce_pkg::CS_USB;
            end else if (rising) begin
                cs_next = bvce_pkg::CS_CHARGING;
            end else if (prev_state_reg == bvce_pkg::CS_CHARGING && holding
                         && trend_reg > bvce_pkg::KEEP_TREND) begin
                cs_next = bvce_pkg::CS_CHARGING;
            end else begin
                cs_next = bvce_pkg::CS_BATTERY;
            end
            shown_next = pct_reg;
            pct_out    = (cs_next != bvce_pkg::CS_FULL && pct_reg > bvce_pkg::PCT_CAP)
                         ? bvce_pkg::PCT_CAP : pct_reg;
        end

        fin_go = (state_reg == bvce_pkg::ST_FIN) && (!m_valid_reg || m_ready);
    end

    // ------------------------------------------------------------------
    // Next state and divider requests
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            bvce_pkg::ST_IDLE: begin
                if (s_valid) state_next = bvce_pkg::ST_COND;
            end
            bvce_pkg::ST_COND: state_next = bvce_pkg::ST_READ;
            bvce_pkg::ST_READ: state_next = bvce_pkg::ST_SPAN;
            bvce_pkg::ST_SPAN: begin
                state_next = trend_ok ? bvce_pkg::ST_MUL : bvce_pkg::ST_PCT;
            end
            bvce_pkg::ST_MUL: begin
                // The divider's input register follows the multiplier directly.
                div_req.start    = 1'b1;
                div_req.dividend = DW'(dv_abs_reg * bvce_pkg::MS_PER_MIN);
                div_req.divisor  = span_reg;
                state_next       = bvce_pkg::ST_TWAIT;
            end
            bvce_pkg::ST_TWAIT: begin
                if (div_rsp.done) state_next = bvce_pkg::ST_PCT;
            end
            bvce_pkg::ST_PCT: begin
                if (pct_d <= 15'sd0 || pct_n100 < 22'(pct_d) || pct_n > pct_d) begin
                    state_next = bvce_pkg::ST_FIN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(pct_n100[19:0]);
                    div_req.divisor  = DW'(pct_d[13:0]);
                    state_next       = bvce_pkg::ST_PWAIT;
                end
            end
            bvce_pkg::ST_PWAIT: begin
                if (div_rsp.done) state_next = bvce_pkg::ST_FIN;
            end
            bvce_pkg::ST_FIN: begin
                if (fin_go) state_next = bvce_pkg::ST_IDLE;
            end
            default: state_next = bvce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bvce_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == bvce_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // Item datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg  <= s_raw_mv;
            time_reg <= s_time_ms;
            usb_reg  <= s_usb_present;
        end
        if (state_reg == bvce_pkg::ST_COND) begin
            mv_reg <= cond_mv;
        end
        if (store_en) begin
            newest_mv_reg <= cond_mv;
            newest_ms_reg <= time_reg;
        end
        if (state_reg == bvce_pkg::ST_SPAN) begin
            dv_abs_reg <= dv[13] ? 13'(-dv) : dv[12:0];
            dv_neg_reg <= dv[13];
            span_reg   <= span_u;
            trend_reg  <= '0;
        end
        if (state_reg == bvce_pkg::ST_TWAIT && div_rsp.done) begin
            trend_reg <= trend_sat;
        end
        if (state_reg == bvce_pkg::ST_PCT) begin
            if (pct_d <= 15'sd0) begin
                pct_reg <= (pct_n > 15'sd0) ? bvce_pkg::PCT_MAX : bvce_pkg::PCT_MIN;
            end else if (pct_n100 < 22'(pct_d)) begin
                pct_reg <= bvce_pkg::PCT_MIN;
            end else begin
                pct_reg <= bvce_pkg::PCT_MAX;
            end
        end
        if (state_reg == bvce_pkg::ST_PWAIT && div_rsp.done) begin
            pct_reg <= div_rsp.quotient[6:0];
        end
        if (fin_go) begin
            out_mv_reg    <= mv_reg;
            out_trend_reg <= trend_reg;
            out_pct_reg   <= pct_out;
            out_state_reg <= cs_next;
            out_rail_reg  <= rail_reg;
        end
    end

    // ------------------------------------------------------------------
    // State carried between items, and the output valid flag
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_reg       <= 1'b0;
            last_good_reg  <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            streak_reg     <= '0;
            prev_state_reg <= bvce_pkg::CS_BATTERY;
            shown_reg      <= bvce_pkg::PCT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == bvce_pkg::ST_COND) begin
                rail_reg <= rail_next;
                if (lg_update) last_good_reg <= cond_mv;
            end
            if (store_en) begin
                head_reg <= head_next;
                if (count_reg != CNT_W'(HISTORY_DEPTH)) count_reg <= count_reg + 1'b1;
            end
            if (fin_go) begin
                streak_reg     <= streak_next;
                prev_state_reg <= cs_next;
                shown_reg      <= shown_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_battery_mv       = out_mv_reg;
    assign m_trend_mv_per_min = out_trend_reg;
    assign m_percent          = out_pct_reg;
    assign m_charge_state     = out_state_reg;
    assign m_rail_latched     = out_rail_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Once an item is taken the block stays busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // The divider is never restarted while it is still working.
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The ring fill count never passes its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history fill count out of range");

    // Every result carries a percent from 1 to 100.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_percent >= bvce_pkg::PCT_MIN && m_percent <= bvce_pkg::PCT_MAX))
        else $error("percent out of range");

    // While latched on the rail the state is battery or USB only.
    a_rail_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rail_latched |-> (m_charge_state == bvce_pkg::CS_BATTERY
                                       || m_charge_state == bvce_pkg::CS_USB))
        else $error("charging state reported while rail latched");

endmodule
